// ===== rtl/core/relay_fault_monitor_unit_defines.svh =====
// Assertion macros shared by the relay fault monitor RTL.
// The checks are compiled in unless SYNTH is defined.
`ifndef RELAY_FAULT_MONITOR_UNIT_DEFINES_SVH
`define RELAY_FAULT_MONITOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define RFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("relay fault monitor: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("relay fault monitor: next-cycle check failed");

`else

`define RFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/rfm_pkg.sv =====
package rfm_pkg;

    // Field and register widths.
    localparam int ADC_BITS   = 10;
    localparam int TIME_W     = 8;
    localparam int TICK_W     = 9;
    localparam int ERR_W      = 4;
    localparam int CMD_W      = 3;
    localparam int CFG_DATA_W = (ADC_BITS > TIME_W) ? ADC_BITS : TIME_W;
    localparam int CFG_IDX_W  = 3;

    // Relay modes.
    typedef enum logic [2:0] {
        MODE_OPEN    = 3'd0,
        MODE_CLOSING = 3'd1,
        MODE_CLOSED  = 3'd2,
        MODE_OPENING = 3'd3,
        MODE_ERROR   = 3'd4
    } t_mode;

    // Command codes carried by an input transaction.
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWITCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACK    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_MARGIN    = 3'd4;

    // Configuration reset values.
    localparam logic [ADC_BITS-1:0] RST_THRESHOLD_HIGH = ADC_BITS'(768);
    localparam logic [ADC_BITS-1:0] RST_THRESHOLD_LOW  = ADC_BITS'(256);
    localparam logic [TIME_W-1:0]   RST_CLOSE_TIME     = TIME_W'(10);
    localparam logic [TIME_W-1:0]   RST_OPEN_TIME      = TIME_W'(10);
    localparam logic [TIME_W-1:0]   RST_TIME_MARGIN    = TIME_W'(5);

    // Error mask bits.
    localparam logic [ERR_W-1:0] ERR_STUCK    = 4'b0001;
    localparam logic [ERR_W-1:0] ERR_SHORT    = 4'b0010;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL  = 4'b0100;
    localparam logic [ERR_W-1:0] ERR_BROWNOUT = 4'b1000;

    // Configuration register set.
    typedef struct packed {
        logic [ADC_BITS-1:0] threshold_high;
        logic [ADC_BITS-1:0] threshold_low;
        logic [TIME_W-1:0]   close_time;
        logic [TIME_W-1:0]   open_time;
        logic [TIME_W-1:0]   time_margin;
    } t_cfg;

    // Supervisor state, also the payload of one result.
    typedef struct packed {
        t_mode             mode;
        logic [ERR_W-1:0]  fault_mask;
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] tick_limit;
        logic              drive;
        logic              change;
    } t_state;

endpackage

// ===== rtl/core/rfm_step.sv =====
module rfm_step
    import rfm_pkg::*;
(
    input  t_state              i_state,
    input  t_cfg                i_cfg,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic                i_drive_readback,
    output t_state              o_next,
    output logic                o_state_led,
    output logic                o_error_led
);

    // An error drops the drive and enters the error mode; the change flag
    // is set only when the mask gains a new bit.
    function automatic t_state f_raise(input t_state s, input logic [ERR_W-1:0] bits);
        t_state r;
        r            = s;
        r.drive      = 1'b0;
        r.fault_mask = s.fault_mask | bits;
        r.mode       = MODE_ERROR;
        if ((s.fault_mask | bits) != s.fault_mask) begin
            r.change = 1'b1;
        end
        return r;
    endfunction

    logic w_band_high;
    logic w_band_low;
    logic w_in_transit;
    logic w_close_done;
    logic w_open_done;

    // ADC bands; the high band is tested first where the thresholds overlap.
    assign w_band_high  = (i_adc_sample >= i_cfg.threshold_high);
    assign w_band_low   = (i_adc_sample <= i_cfg.threshold_low);
    assign w_in_transit = (i_state.mode == MODE_CLOSING) || (i_state.mode == MODE_OPENING);
    assign w_close_done = (i_state.tick_count >= {1'b0, i_cfg.close_time});
    assign w_open_done  = (i_state.tick_count >= {1'b0, i_cfg.open_time});

    // Next state for one transaction.
    always_comb begin
        o_next = i_state;
        case (i_command)
            CMD_TICK: begin
                if (i_drive_readback != i_state.drive) begin
                    o_next = f_raise(i_state, ERR_SHORT);
                end else if (w_in_transit) begin
                    if (i_state.tick_count >= i_state.tick_limit) begin
                        o_next = f_raise(i_state, ERR_STUCK);
                    end else begin
                        o_next.tick_count = i_state.tick_count + 1'b1;
                    end
                end
            end
            CMD_SAMPLE: begin
                if (i_state.mode > MODE_ERROR) begin
                    o_next = f_raise(i_state, ERR_ILLEGAL);
                end else if (w_band_high) begin
                    if (i_state.mode == MODE_OPEN) begin
                        o_next = f_raise(i_state, ERR_STUCK);
                    end else if (i_state.mode == MODE_CLOSING && w_close_done) begin
                        o_next.mode = MODE_CLOSED;
                    end
                end else if (w_band_low) begin
                    if (i_state.mode == MODE_CLOSED) begin
                        o_next = f_raise(i_state, ERR_STUCK);
                    end else if (i_state.mode == MODE_OPENING && w_open_done) begin
                        o_next.mode = MODE_OPEN;
                    end
                end else if (i_state.mode == MODE_OPEN || i_state.mode == MODE_CLOSED) begin
                    o_next = f_raise(i_state, ERR_BROWNOUT);
                end
            end
            CMD_SWITCH: begin
                if (i_state.mode == MODE_OPEN) begin
                    o_next.tick_count = '0;
                    o_next.tick_limit = {1'b0, i_cfg.close_time} + {1'b0, i_cfg.time_margin};
                    o_next.drive      = 1'b1;
                    o_next.mode       = MODE_CLOSING;
                end else if (i_state.mode == MODE_CLOSED) begin
                    o_next.tick_count = '0;
                    o_next.tick_limit = {1'b0, i_cfg.open_time} + {1'b0, i_cfg.time_margin};
                    o_next.drive      = 1'b0;
                    o_next.mode       = MODE_OPENING;
                end
            end
            CMD_CLEAR: begin
                if (i_state.fault_mask != '0) begin
                    o_next.change = 1'b1;
                end
                o_next.fault_mask = '0;
                o_next.mode       = MODE_OPEN;
            end
            CMD_ACK: begin
                o_next.change = 1'b0;
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

    // Indicator outputs follow the state after the transaction.
    always_comb begin
        o_state_led = (o_next.mode inside {MODE_CLOSING, MODE_CLOSED});
        o_error_led = (o_next.fault_mask != '0);
    end

endmodule

// ===== rtl/core/relay_fault_monitor_unit.sv =====
// Relay fault monitor: supervises a relay coil through tick, ADC sample,
// switch, clear and acknowledge commands and returns one result per input
// transaction, showing the relay mode, sticky error flags, change flag, coil
// drive and the two indicator levels as they stand after that command. A
// transaction is taken into an input register, its effect on the supervisor
// state is worked out combinationally and written together with the result
// register once that register is free or drains, and one transaction is
// accepted every cycle while the output side keeps up. Configuration writes
// take effect at once and are meant to be made while no transaction is in
// flight. No clearing pass follows reset.
`include "relay_fault_monitor_unit_defines.svh"

module relay_fault_monitor_unit
    import rfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [ADC_BITS-1:0]   i_adc_sample,
    input  logic                  i_drive_readback,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_relay_state,
    output logic [ERR_W-1:0]      o_error_flags,
    output logic                  o_error_changed,
    output logic                  o_drive_level,
    output logic                  o_state_led,
    output logic                  o_error_led
);

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              n_state;
    logic                r_in_valid;
    logic [CMD_W-1:0]    r_in_command;
    logic [ADC_BITS-1:0] r_in_sample;
    logic                r_in_readback;
    logic                r_out_valid;
    t_state              r_out_state;
    logic                r_out_state_led;
    logic                r_out_error_led;
    logic                n_state_led;
    logic                n_error_led;
    logic                w_advance;
    logic                w_in_take;

    // A held transaction moves on when the result register is free or drains.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || w_advance);
    assign w_in_take  = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_high <= RST_THRESHOLD_HIGH;
            r_cfg.threshold_low  <= RST_THRESHOLD_LOW;
            r_cfg.close_time     <= RST_CLOSE_TIME;
            r_cfg.open_time      <= RST_OPEN_TIME;
            r_cfg.time_margin    <= RST_TIME_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD_HIGH: r_cfg.threshold_high <= i_cfg_data[ADC_BITS-1:0];
                CFG_THRESHOLD_LOW:  r_cfg.threshold_low  <= i_cfg_data[ADC_BITS-1:0];
                CFG_CLOSE_TIME:     r_cfg.close_time     <= i_cfg_data[TIME_W-1:0];
                CFG_OPEN_TIME:      r_cfg.open_time      <= i_cfg_data[TIME_W-1:0];
                CFG_TIME_MARGIN:    r_cfg.time_margin    <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_command  <= i_command;
            r_in_sample   <= i_adc_sample;
            r_in_readback <= i_drive_readback;
        end
    end

    // State update for the held transaction.
    rfm_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_command        (r_in_command),
        .i_adc_sample     (r_in_sample),
        .i_drive_readback (r_in_readback),
        .o_next           (n_state),
        .o_state_led      (n_state_led),
        .o_error_led      (n_error_led)
    );

    // Supervisor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_OPEN;
            r_state.fault_mask <= '0;
            r_state.tick_count <= '0;
            r_state.tick_limit <= '0;
            r_state.drive      <= 1'b0;
            r_state.change     <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_state     <= n_state;
            r_out_state_led <= n_state_led;
            r_out_error_led <= n_error_led;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relay_state   = r_out_state.mode;
    assign o_error_flags   = r_out_state.fault_mask;
    assign o_error_changed = r_out_state.change;
    assign o_drive_level   = r_out_state.drive;
    assign o_state_led     = r_out_state_led;
    assign o_error_led     = r_out_error_led;

    // The error mode always carries a flag and a released coil.
    `RFM_ASSERT_IMP(a_error_mode_safe, i_clk, i_rst_n, r_state.mode == MODE_ERROR, (r_state.fault_mask != '0) && !r_state.drive)

    // A transition never counts past its limit.
    `RFM_ASSERT_IMP(a_tick_within_limit, i_clk, i_rst_n, (r_state.mode == MODE_CLOSING) || (r_state.mode == MODE_OPENING), r_state.tick_count <= r_state.tick_limit)

    // The supervisor state moves only when a transaction is processed.
    `RFM_ASSERT_NEXT(a_state_held, i_clk, i_rst_n, !w_advance, $stable(r_state))

    // A processed transaction always leaves a result behind.
    `RFM_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_advance, r_out_valid)

endmodule

// ===== dv/tb.sv =====
module tb;
    import rfm_pkg::*;

    // Command codes that the block leaves without effect.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // Bands of the sensed output level.
    localparam int BAND_HIGH = 0;
    localparam int BAND_LOW  = 1;
    localparam int BAND_MID  = 2;

    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
    localparam logic [TIME_W-1:0]   TIME_MAX = '1;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int END_SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [2:0]       relay_state;
        logic [ERR_W-1:0] error_flags;
        logic             error_changed;
        logic             drive_level;
        logic             state_led;
        logic             error_led;
    } t_status;

    // Ports of the block.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command = CMD_ACK;
    logic [ADC_BITS-1:0]   i_adc_sample = '0;
    logic                  i_drive_readback = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_relay_state;
    logic [ERR_W-1:0]      o_error_flags;
    logic                  o_error_changed;
    logic                  o_drive_level;
    logic                  o_state_led;
    logic                  o_error_led;

    // Supervisor copy, starting from the reset state.
    logic [ADC_BITS-1:0] cfg_high = RST_THRESHOLD_HIGH;
    logic [ADC_BITS-1:0] cfg_low = RST_THRESHOLD_LOW;
    logic [TIME_W-1:0]   cfg_close = RST_CLOSE_TIME;
    logic [TIME_W-1:0]   cfg_open = RST_OPEN_TIME;
    logic [TIME_W-1:0]   cfg_margin = RST_TIME_MARGIN;
    t_mode               mdl_mode = MODE_OPEN;
    logic [ERR_W-1:0]    mdl_faults = '0;
    logic [TICK_W-1:0]   mdl_ticks = '0;
    logic [TICK_W-1:0]   mdl_limit = '0;
    logic                mdl_drive = 1'b0;
    logic                mdl_changed = 1'b0;

    t_status pending_status[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off_len = 0;
    int      hold_off_seq = 0;
    int      hold_off_seen = 0;
    int      hold_off_left = 0;

    relay_fault_monitor_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Latch an error into the mask, drop the coil and enter the error mode.
    function automatic void raise_fault(input logic [ERR_W-1:0] new_fault);
        logic [ERR_W-1:0] prior;
        prior = mdl_faults;
        mdl_drive = 1'b0;
        mdl_faults = mdl_faults | new_fault;
        mdl_mode = MODE_ERROR;
        if (mdl_faults != prior) mdl_changed = 1'b1;
    endfunction

    // Apply one command to the supervisor copy and return the status it reports.
    function automatic t_status relay_status_after(input logic [CMD_W-1:0] cmd,
                                                   input logic [ADC_BITS-1:0] level,
                                                   input logic readback);
        t_status res;
        case (cmd)
            CMD_TICK: begin
                if (readback != mdl_drive) raise_fault(ERR_SHORT);
                if (mdl_mode == MODE_CLOSING || mdl_mode == MODE_OPENING) begin
                    if (mdl_ticks >= mdl_limit) raise_fault(ERR_STUCK);
                    else mdl_ticks = mdl_ticks + 1'b1;
                end
            end
            CMD_SAMPLE: begin
                if (mdl_mode > MODE_ERROR) begin
                    raise_fault(ERR_ILLEGAL);
                end else if (level >= cfg_high) begin
                    if (mdl_mode == MODE_OPEN) raise_fault(ERR_STUCK);
                    else if (mdl_mode == MODE_CLOSING && mdl_ticks >= cfg_close)
                        mdl_mode = MODE_CLOSED;
                end else if (level <= cfg_low) begin
                    if (mdl_mode == MODE_CLOSED) raise_fault(ERR_STUCK);
                    else if (mdl_mode == MODE_OPENING && mdl_ticks >= cfg_open)
                        mdl_mode = MODE_OPEN;
                end else if (mdl_mode == MODE_OPEN || mdl_mode == MODE_CLOSED) begin
                    raise_fault(ERR_BROWNOUT);
                end
            end
            CMD_SWITCH: begin
                if (mdl_mode == MODE_OPEN) begin
                    mdl_ticks = '0;
                    mdl_limit = {1'b0, cfg_close} + {1'b0, cfg_margin};
                    mdl_drive = 1'b1;
                    mdl_mode = MODE_CLOSING;
                end else if (mdl_mode == MODE_CLOSED) begin
                    mdl_ticks = '0;
                    mdl_limit = {1'b0, cfg_open} + {1'b0, cfg_margin};
                    mdl_drive = 1'b0;
                    mdl_mode = MODE_OPENING;
                end
            end
            CMD_CLEAR: begin
                if (mdl_faults != '0) mdl_changed = 1'b1;
                mdl_faults = '0;
                mdl_mode = MODE_OPEN;
            end
            CMD_ACK: mdl_changed = 1'b0;
            default: ;
        endcase
        res.relay_state = mdl_mode;
        res.error_flags = mdl_faults;
        res.error_changed = mdl_changed;
        res.drive_level = mdl_drive;
        res.state_led = (mdl_mode == MODE_CLOSING || mdl_mode == MODE_CLOSED);
        res.error_led = |mdl_faults;
        return res;
    endfunction

    // Pick a sensed level inside one band of the current thresholds; any level when the middle band is empty.
    function automatic logic [ADC_BITS-1:0] level_in_band(input int band);
        case (band)
            BAND_HIGH: return $urandom_range(cfg_high, ADC_MAX);
            BAND_LOW:  return $urandom_range(0, cfg_low);
            default: begin
                if (cfg_high > cfg_low + 1) return $urandom_range(cfg_low + 1, cfg_high - 1);
                return $urandom;
            end
        endcase
    endfunction

    // Offer one transaction, wait for it to be taken and record its status.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [ADC_BITS-1:0] level,
                                input logic readback);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_adc_sample <= level;
        i_drive_readback <= readback;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_status.push_back(relay_status_after(cmd, level, readback));
    endtask

    // Stop offering and wait until every outstanding status has been returned.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            CFG_THRESHOLD_HIGH: cfg_high = data[ADC_BITS-1:0];
            CFG_THRESHOLD_LOW:  cfg_low = data[ADC_BITS-1:0];
            CFG_CLOSE_TIME:     cfg_close = data[TIME_W-1:0];
            CFG_OPEN_TIME:      cfg_open = data[TIME_W-1:0];
            CFG_TIME_MARGIN:    cfg_margin = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // Write the whole register set; the block must already be drained.
    task automatic configure(input logic [ADC_BITS-1:0] high, input logic [ADC_BITS-1:0] low,
                             input logic [TIME_W-1:0] close_t, input logic [TIME_W-1:0] open_t,
                             input logic [TIME_W-1:0] margin);
        write_reg(CFG_THRESHOLD_HIGH, high);
        write_reg(CFG_THRESHOLD_LOW, low);
        write_reg(CFG_CLOSE_TIME, close_t);
        write_reg(CFG_OPEN_TIME, open_t);
        write_reg(CFG_TIME_MARGIN, margin);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed switch cycles with random content, plus some noise.
    task automatic run_relay_cycles(input int count);
        logic [CMD_W-1:0]    cmd;
        logic [ADC_BITS-1:0] level;
        logic                readback;
        int                  roll;
        logic [TIME_W-1:0]   needed;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            cmd = CMD_TICK;
            level = $urandom;
            readback = $urandom;
            if (roll < 12) begin
                cmd = $urandom_range(0, 2 ** CMD_W - 1);
            end else begin
                roll = $urandom_range(99);
                case (mdl_mode)
                    MODE_OPEN, MODE_CLOSED: begin
                        if (roll < 20) begin
                            cmd = CMD_SAMPLE;
                            level = level_in_band(mdl_mode == MODE_OPEN ? BAND_LOW : BAND_HIGH);
                        end else if (mdl_changed && roll < 40) begin
                            cmd = CMD_ACK;
                        end else begin
                            cmd = CMD_SWITCH;
                        end
                    end
                    MODE_CLOSING, MODE_OPENING: begin
                        needed = (mdl_mode == MODE_CLOSING) ? cfg_close : cfg_open;
                        if (mdl_ticks < needed || roll < 20) begin
                            readback = ($urandom_range(99) < 97) ? mdl_drive : !mdl_drive;
                        end else if (roll < 90) begin
                            cmd = CMD_SAMPLE;
                            level = level_in_band(mdl_mode == MODE_CLOSING ? BAND_HIGH
                                                                           : BAND_LOW);
                        end else begin
                            cmd = CMD_SAMPLE;
                            level = level_in_band($urandom_range(BAND_HIGH, BAND_MID));
                        end
                    end
                    default: cmd = (mdl_changed && roll < 40) ? CMD_ACK : CMD_CLEAR;
                endcase
            end
            send_command(cmd, level, readback);
        end
    endtask

    // Every command and the corner cases of each, with the reset register values.
    task automatic test_command_set();
        send_command(CMD_ACK, '0, 1'b0);
        send_command(CMD_TICK, '0, 1'b0);
        // Readback disagrees with an idle coil: transistor short.
        send_command(CMD_TICK, ADC_MAX, 1'b1);
        send_command(CMD_SWITCH, '0, 1'b0);
        send_command(CMD_SAMPLE, ADC_MAX, 1'b0);
        send_command(CMD_TICK, '0, 1'b0);
        send_command(CMD_ACK, '0, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
        send_command(CMD_ACK, '0, 1'b0);
        // Clearing with nothing set leaves the change flag alone.
        send_command(CMD_CLEAR, '0, 1'b0);
        send_command(CMD_SPARE_5, ADC_MAX, 1'b1);
        send_command(CMD_SPARE_6, '0, 1'b0);
        send_command(CMD_SPARE_7, $urandom, $urandom);
        // High level while open means the contacts are stuck.
        send_command(CMD_SAMPLE, ADC_MAX, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
        // Middle band while settled: brownout.
        send_command(CMD_SAMPLE, 10'd512, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
        send_command(CMD_SAMPLE, '0, 1'b0);
        send_command(CMD_SWITCH, '0, 1'b0);
        send_command(CMD_SWITCH, '0, 1'b0);
        // Closed level before the minimum time is not taken as closed.
        send_command(CMD_SAMPLE, ADC_MAX, 1'b0);
        send_command(CMD_SAMPLE, '0, 1'b0);
        // Clearing mid-transition returns to open with the coil still driven.
        send_command(CMD_CLEAR, '0, 1'b0);
        send_command(CMD_TICK, '0, 1'b1);
        send_command(CMD_TICK, '0, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
    endtask

    // Zero times with overlapping and then widest thresholds.
    task automatic test_threshold_extremes();
        wait_drained();
        configure('0, ADC_MAX, '0, '0, '0);
        send_command(CMD_SWITCH, '0, 1'b0);
        // Overlap: the high band wins, so a zero level still confirms closing.
        send_command(CMD_SAMPLE, '0, 1'b0);
        send_command(CMD_SWITCH, '0, 1'b0);
        // Limit of zero: the first tick of a transition already counts as stuck.
        send_command(CMD_TICK, '0, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
        wait_drained();
        configure(ADC_MAX, '0, '0, '0, '0);
        send_command(CMD_SWITCH, '0, 1'b0);
        send_command(CMD_SAMPLE, ADC_MAX - 1'b1, 1'b0);
        send_command(CMD_SAMPLE, ADC_MAX, 1'b0);
        // Open level while closed means the contacts are stuck.
        send_command(CMD_SAMPLE, '0, 1'b0);
        send_command(CMD_CLEAR, '0, 1'b0);
        send_command(CMD_ACK, '0, 1'b0);
    endtask

    // Random cycles under fresh short timings and a given idling pattern.
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        logic [ADC_BITS-1:0] high;
        logic [ADC_BITS-1:0] low;
        wait_drained();
        high = $urandom_range(300, ADC_MAX);
        low = ($urandom_range(99) < 10) ? $urandom_range(high, ADC_MAX)
                                        : $urandom_range(0, high);
        configure(high, low, $urandom_range(0, 12), $urandom_range(0, 12),
                  $urandom_range(0, 6));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        run_relay_cycles(count);
    endtask

    // Largest timing registers: long transitions and a 9-bit limit.
    task automatic test_longest_times();
        wait_drained();
        configure(ADC_MAX, '0, TIME_MAX, TIME_MAX, TIME_MAX);
        send_idle_pct = 0;
        recv_stall_pct = 25;
        run_relay_cycles(150);
    endtask

    // Output held off while input keeps coming, then a full drain before resuming.
    task automatic test_output_backpressure();
        wait_drained();
        configure(RST_THRESHOLD_HIGH, RST_THRESHOLD_LOW, 3, 3, 2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_len = 60;
        hold_off_seq = hold_off_seq + 1;
        run_relay_cycles(40);
        wait_drained();
        run_relay_cycles(20);
    endtask

    // Output side: check each returned status and pace the ready signal.
    always @(posedge i_clk) begin : status_monitor
        t_status got;
        t_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_relay_state, o_error_flags, o_error_changed, o_drive_level,
                   o_state_led, o_error_led};
            if (pending_status.size() == 0) begin
                $error("status returned with no transaction outstanding");
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                if (got.relay_state != want.relay_state) begin
                    $error("relay_state: expected %0d, actual %0d",
                           want.relay_state, got.relay_state);
                    fail_count++;
                end
                if (got.error_flags != want.error_flags) begin
                    $error("error_flags: expected %0h, actual %0h",
                           want.error_flags, got.error_flags);
                    fail_count++;
                end
                if (got.error_changed != want.error_changed) begin
                    $error("error_changed: expected %0d, actual %0d",
                           want.error_changed, got.error_changed);
                    fail_count++;
                end
                if (got.drive_level != want.drive_level) begin
                    $error("drive_level: expected %0d, actual %0d",
                           want.drive_level, got.drive_level);
                    fail_count++;
                end
                if (got.state_led != want.state_led) begin
                    $error("state_led: expected %0d, actual %0d",
                           want.state_led, got.state_led);
                    fail_count++;
                end
                if (got.error_led != want.error_led) begin
                    $error("error_led: expected %0d, actual %0d",
                           want.error_led, got.error_led);
                    fail_count++;
                end
            end
        end
        // A new hold-off request starts a stretch of forced stalls.
        if (hold_off_seen != hold_off_seq) begin
            hold_off_seen = hold_off_seq;
            hold_off_left = hold_off_len;
        end
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_command_set();
        test_threshold_extremes();
        test_random_traffic(500, 0, 0);
        test_random_traffic(500, 70, 0);
        test_random_traffic(500, 0, 70);
        test_random_traffic(500, 25, 25);
        test_longest_times();
        test_output_backpressure();
        wait_drained();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
